// File: rtl/hcta_pkg.sv
// hcta_pkg: shared widths, constants, codes and types of the history counter table
// used by every file of the block but hcta_ram; depends on nothing

package hcta_pkg;

	// field widths
	localparam int unsigned SCORE_W  = 17;
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned PIECE_W  = 4;
	localparam int unsigned SQUARE_W = 6;
	localparam int unsigned DEPTH_W  = 6;
	localparam int unsigned DSQ_W    = 2 * DEPTH_W;
	localparam int unsigned IDX_W    = PIECE_W + 2;

	// configuration port
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	// constants
	localparam logic [SCORE_W-1:0]      ENTRY_MAX    = 17'h1FFFF;
	localparam logic [SCORE_W-1:0]      THRESH_RESET = 17'd100000;
	localparam logic signed [IDX_W-1:0] PIECE_OFFSET = 6'sd6;

	// register index, taken from paddr[2]
	localparam logic REG_AGE_THRESHOLD = 1'b0;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_UPDATE = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_AGE,
		ST_AGE_LAST
	} state_t;

	// decoded request handed to the engine
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic               bad;
		logic [DEPTH_W-1:0] depth;
	} op_t;

	// result word from the engine
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               aged;
		logic               rejected;
	} rsp_t;

endpackage

// File: rtl/hcta_if.sv
// hcta_req_if / hcta_rsp_if: valid/ready channels of the history counter table
// depends on hcta_pkg for the field widths

interface hcta_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [hcta_pkg::FUNC_W-1:0]             func;
	logic signed [hcta_pkg::PIECE_W-1:0]     piece;
	logic [hcta_pkg::SQUARE_W-1:0]           square;
	logic [hcta_pkg::DEPTH_W-1:0]            depth;

	modport source (output valid, func, piece, square, depth, input ready);
	modport sink (input valid, func, piece, square, depth, output ready);
endinterface

interface hcta_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [hcta_pkg::SCORE_W-1:0]  score;
	logic                          aged;
	logic                          rejected;

	modport source (output valid, score, aged, rejected, input ready);
	modport sink (input valid, score, aged, rejected, output ready);
endinterface

// File: rtl/hcta_ram.sv
// hcta_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module hcta_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 832,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/hcta_cfg.sv
// hcta_cfg: apb-style register file holding the aging threshold
// depends on hcta_pkg

module hcta_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hcta_pkg::PADDR_W-1:0]  paddr,
	input  logic [hcta_pkg::PDATA_W-1:0]  pwdata,
	output logic [hcta_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [hcta_pkg::SCORE_W-1:0]  threshold
);

	logic [hcta_pkg::SCORE_W-1:0] thresh_q;
	logic                         hit;

	assign hit    = (paddr[2] == hcta_pkg::REG_AGE_THRESHOLD);
	assign pready = 1'b1;

	// threshold register, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= hcta_pkg::THRESH_RESET;
		end else if (psel && penable && pwrite && hit) begin
			thresh_q <= pwdata[hcta_pkg::SCORE_W-1:0];
		end
	end

	// read back
	assign prdata = hit ? hcta_pkg::PDATA_W'(thresh_q) : '0;

	assign threshold = thresh_q;

endmodule

// File: rtl/hcta_eng.sv
// hcta_eng: sequencer doing read-modify-write of one counter plus clear and aging sweeps
// depends on hcta_pkg; drives the ports of one hcta_ram

module hcta_eng #(
	parameter int unsigned DEPTH = 832,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  hcta_pkg::op_t                 op,
	input  logic [AW-1:0]                 pos,
	input  logic [hcta_pkg::SCORE_W-1:0]  threshold,
	input  logic                          out_free,
	output logic                          idle,
	output logic                          done,
	output hcta_pkg::rsp_t                rsp,
	output logic                          we,
	output logic [AW-1:0]                 waddr,
	output logic [hcta_pkg::SCORE_W-1:0]  wdata,
	output logic                          re,
	output logic [AW-1:0]                 raddr,
	input  logic [hcta_pkg::SCORE_W-1:0]  rdata
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	hcta_pkg::state_t             state_q, state_d;
	hcta_pkg::op_t                op_q;
	logic [AW-1:0]                pos_q;
	logic [AW-1:0]                cnt_q, cnt_d;
	logic [hcta_pkg::DSQ_W-1:0]   dsq;
	logic [hcta_pkg::SCORE_W:0]   sum;
	logic [hcta_pkg::SCORE_W-1:0] sat;
	logic                         over;

	// state and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcta_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// request held while the counter is read
	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			pos_q <= pos;
		end
	end

	// update arithmetic: add depth squared, saturate, compare with threshold
	assign dsq  = hcta_pkg::DSQ_W'(op_q.depth) * hcta_pkg::DSQ_W'(op_q.depth);
	assign sum  = {1'b0, rdata} + (hcta_pkg::SCORE_W + 1)'(dsq);
	assign sat  = sum[hcta_pkg::SCORE_W] ? hcta_pkg::ENTRY_MAX : sum[hcta_pkg::SCORE_W-1:0];
	assign over = (sat > threshold);

	assign idle = (state_q == hcta_pkg::ST_IDLE);

	// next state, memory access and result
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done    = 1'b0;
		rsp     = '0;
		we      = 1'b0;
		waddr   = cnt_q;
		wdata   = '0;
		re      = 1'b0;
		raddr   = pos;
		case (state_q)
			hcta_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = '0;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = hcta_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			hcta_pkg::ST_IDLE: begin
				re    = start;
				raddr = pos;
				if (start) begin
					state_d = hcta_pkg::ST_EXEC;
				end
			end
			hcta_pkg::ST_EXEC: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = hcta_pkg::ST_IDLE;
					cnt_d   = '0;
					case (op_q.func)
						hcta_pkg::FUNC_UPDATE: begin
							rsp.rejected = op_q.bad;
							if (!op_q.bad) begin
								we        = 1'b1;
								waddr     = pos_q;
								wdata     = sat;
								rsp.aged  = over;
								rsp.score = over ? (sat >> 1) : sat;
								if (over) begin
									state_d = hcta_pkg::ST_AGE;
								end
							end
						end
						hcta_pkg::FUNC_LOOKUP: begin
							rsp.rejected = op_q.bad;
							if (!op_q.bad) begin
								rsp.score = rdata;
							end
						end
						hcta_pkg::FUNC_CLEAR: begin
							state_d = hcta_pkg::ST_CLEAR;
						end
						default: begin
							rsp = '0;
						end
					endcase
				end
			end
			hcta_pkg::ST_AGE: begin
				// read entry n while writing back entry n-1 halved
				re    = 1'b1;
				raddr = cnt_q;
				if (cnt_q != '0) begin
					we    = 1'b1;
					waddr = cnt_q - 1'b1;
					wdata = rdata >> 1;
				end
				if (cnt_q == LAST) begin
					state_d = hcta_pkg::ST_AGE_LAST;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			hcta_pkg::ST_AGE_LAST: begin
				we      = 1'b1;
				waddr   = LAST;
				wdata   = rdata >> 1;
				cnt_d   = '0;
				state_d = hcta_pkg::ST_IDLE;
			end
			default: begin
				state_d = hcta_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/history_counter_table_with_aging_core.sv
// history_counter_table_with_aging_core: request decode, output register and wiring
// depends on hcta_pkg, hcta_if, hcta_ram, hcta_cfg and hcta_eng
//
// Usage
//   req carries one word per operation: func (0 update, 1 lookup, 2 clear), a signed
//   piece code, a target square and a search depth. rsp returns exactly one word per
//   request: score, aged and rejected. The user writes the aging threshold over the
//   APB port at address 0 while the block is idle; the block does not enforce this.
// Operation
//   A word's counter is first read from the single-port-read table memory, then
//   modified, written back and loaded into the result register once that register is
//   free; rsp is valid in the cycle after the load. An update that ages the table then
//   runs a halving sweep and a clear runs a zeroing sweep; req is not ready during
//   either sweep. With the default 13 x 64 table DEPTH is 832.
// Reset
//   arst_n clears control state and sets the threshold to 100000; afterwards a
//   zeroing pass runs over all DEPTH (832) entries of the memory before req goes ready.
// Stalls
//   The result register holds a word until rsp.ready; the next request is taken
//   meanwhile and waits in the modify stage until the result register is free.

module history_counter_table_with_aging_core #(
	parameter int unsigned PIECE_KINDS = 13,
	parameter int unsigned SQUARES     = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hcta_pkg::PADDR_W-1:0]  paddr,
	input  logic [hcta_pkg::PDATA_W-1:0]  pwdata,
	output logic [hcta_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	hcta_req_if.sink                      req,
	hcta_rsp_if.source                    rsp
);

	localparam int unsigned DEPTH = PIECE_KINDS * SQUARES;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [hcta_pkg::SCORE_W-1:0]      threshold;
	logic signed [hcta_pkg::IDX_W-1:0] idx;
	logic [hcta_pkg::IDX_W-2:0]        idx_u;
	logic                              bad;
	logic [AW-1:0]                     pos;
	hcta_pkg::op_t                     op;
	hcta_pkg::rsp_t                    eng_rsp;
	hcta_pkg::rsp_t                    rsp_q;
	logic                              out_valid_q;
	logic                              out_free;
	logic                              idle;
	logic                              start;
	logic                              done;
	logic                              we;
	logic                              re;
	logic [AW-1:0]                     waddr;
	logic [AW-1:0]                     raddr;
	logic [hcta_pkg::SCORE_W-1:0]      wdata;
	logic [hcta_pkg::SCORE_W-1:0]      rdata;

	// configuration registers
	hcta_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	// piece code offset into a row index, range check and table address
	assign idx   = hcta_pkg::IDX_W'(req.piece) + hcta_pkg::PIECE_OFFSET;
	assign idx_u = idx[hcta_pkg::IDX_W-2:0];
	assign bad   = idx[hcta_pkg::IDX_W-1]
		|| (int'(idx_u) >= int'(PIECE_KINDS))
		|| (int'(req.square) >= int'(SQUARES));
	assign pos   = bad ? '0 : AW'(int'(idx_u) * int'(SQUARES) + int'(req.square));

	assign op.func  = req.func;
	assign op.bad   = bad;
	assign op.depth = req.depth;

	assign req.ready = idle;
	assign start     = req.valid && idle;

	// sequencer
	hcta_eng #(
		.DEPTH (DEPTH)
	) u_eng (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.pos       (pos),
		.threshold (threshold),
		.out_free  (out_free),
		.idle      (idle),
		.done      (done),
		.rsp       (eng_rsp),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	// score table
	hcta_ram #(
		.WIDTH (hcta_pkg::SCORE_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result register
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.score    = rsp_q.score;
	assign rsp.aged     = rsp_q.aged;
	assign rsp.rejected = rsp_q.rejected;

endmodule

// File: verif/history_counter_table_with_aging_core_test.sv
// history_counter_table_with_aging_core_test: self-checking bench for the history counter table
// directed rows, then random traffic over several aging thresholds, checked against a local model
// depends on hcta_pkg, hcta_if and the history_counter_table_with_aging_core rtl

module history_counter_table_with_aging_core_test;
	import hcta_pkg::*;

	localparam int PIECE_KINDS = 13;
	localparam int SQUARES     = 64;
	localparam int CELLS       = PIECE_KINDS * SQUARES;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 900;
	localparam int PHASE_WORDS = 330;

	localparam logic [FUNC_W-1:0]  FUNC_UNKNOWN = 2'd3;
	localparam logic [PADDR_W-1:0] THRESH_ADDR  = {REG_AGE_THRESHOLD, 2'b00};
	localparam logic [SCORE_W-1:0] THRESH_TOP   = 17'd131071;
	localparam logic [SCORE_W-1:0] THRESH_HIGH  = 17'd127000;
	localparam logic [SCORE_W-1:0] THRESH_LOW   = 17'd4000;

	typedef enum logic {STEP_WORD, STEP_THRESH} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		logic [FUNC_W-1:0] func;
		int                piece;
		int                square;
		int                depth;
		logic              pinned;
		rsp_t              want;
		int unsigned       thresh;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	hcta_req_if req_bus ();
	hcta_rsp_if rsp_bus ();

	history_counter_table_with_aging_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_bus),
		.rsp     (rsp_bus)
	);

	// local copy of the counter table and threshold
	logic [SCORE_W-1:0] counters [CELLS];
	logic [SCORE_W-1:0] age_limit;
	rsp_t               scores_due [$];

	// pinned expectation travels with the word it belongs to
	logic               pin_flag;
	rsp_t               pin_word;

	int                 src_idle_pct;
	int                 snk_idle_pct;
	int                 n_sent;
	int                 n_done;
	int                 errors;

	// directed rows: extremes, rejects, unknown func, clear, aging and saturation edges
	plan_row_t plan [25] = '{
		'{STEP_WORD, FUNC_LOOKUP,  -6,  0,  0, 1'b1, {17'd0,    1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_LOOKUP,   6, 63, 63, 1'b1, {17'd0,    1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_UPDATE,   7,  0, 63, 1'b1, {17'd0,    1'b0, 1'b1}, 0},
		'{STEP_WORD, FUNC_UPDATE,  -8, 63, 63, 1'b1, {17'd0,    1'b0, 1'b1}, 0},
		'{STEP_WORD, FUNC_LOOKUP,  -7,  5,  0, 1'b1, {17'd0,    1'b0, 1'b1}, 0},
		'{STEP_WORD, FUNC_UPDATE,   0, 10, 63, 1'b1, {17'd3969, 1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_UPDATE,   0, 10,  0, 1'b1, {17'd3969, 1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_UPDATE,  -6,  0,  1, 1'b1, {17'd1,    1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_UPDATE,   6, 63, 42, 1'b0, '0,                     0},
		'{STEP_WORD, FUNC_LOOKUP,   0, 10, 21, 1'b1, {17'd3969, 1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_UNKNOWN,  5, 33,  7, 1'b1, {17'd0,    1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_CLEAR,    3, 17,  9, 1'b1, {17'd0,    1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_LOOKUP,   0, 10,  0, 1'b1, {17'd0,    1'b0, 1'b0}, 0},
		'{STEP_THRESH, FUNC_UPDATE, 0,  0,  0, 1'b0, '0,                     0},
		'{STEP_WORD, FUNC_UPDATE,   1,  5,  1, 1'b1, {17'd0,    1'b1, 1'b0}, 0},
		'{STEP_WORD, FUNC_UPDATE,   1,  5,  0, 1'b1, {17'd0,    1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_UPDATE,  -1, 20, 63, 1'b1, {17'd1984, 1'b1, 1'b0}, 0},
		'{STEP_WORD, FUNC_LOOKUP,  -1, 20,  0, 1'b1, {17'd1984, 1'b0, 1'b0}, 0},
		'{STEP_THRESH, FUNC_UPDATE, 0,  0,  0, 1'b0, '0,                131071},
		'{STEP_WORD, FUNC_UPDATE,  -1, 20, 63, 1'b0, '0,                     0},
		'{STEP_WORD, FUNC_LOOKUP,   5, 42, 63, 1'b0, '0,                     0},
		'{STEP_THRESH, FUNC_UPDATE, 0,  0,  0, 1'b0, '0,                  3969},
		'{STEP_WORD, FUNC_UPDATE,   2,  2, 63, 1'b1, {17'd3969, 1'b0, 1'b0}, 0},
		'{STEP_WORD, FUNC_UPDATE,   2,  2,  1, 1'b1, {17'd1985, 1'b1, 1'b0}, 0},
		'{STEP_WORD, FUNC_LOOKUP,  -1, 20,  0, 1'b0, '0,                     0}
	};

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// score after one word, updating the local table on the way
	function automatic rsp_t score_after(input logic [FUNC_W-1:0] f, input logic signed [PIECE_W-1:0] pc,
			input logic [SQUARE_W-1:0] sq, input logic [DEPTH_W-1:0] d);
		int          row;
		int unsigned pos;
		logic [SCORE_W:0] sum;
		rsp_t        r;
		r   = '0;
		row = int'(pc) + int'(PIECE_OFFSET);
		if (f == FUNC_CLEAR) begin
			foreach (counters[i]) counters[i] = '0;
		end else if (f == FUNC_UPDATE || f == FUNC_LOOKUP) begin
			if (row < 0 || row >= PIECE_KINDS || int'(sq) >= SQUARES) begin
				r.rejected = 1'b1;
			end else begin
				pos = row * SQUARES + int'(sq);
				if (f == FUNC_UPDATE) begin
					sum = {1'b0, counters[pos]} + (18'(d) * 18'(d));
					counters[pos] = (sum > {1'b0, ENTRY_MAX}) ? ENTRY_MAX : sum[SCORE_W-1:0];
					// aging halves every entry, the updated one too
					if (counters[pos] > age_limit) begin
						foreach (counters[i]) counters[i] = counters[i] >> 1;
						r.aged = 1'b1;
					end
				end
				r.score = counters[pos];
			end
		end
		return r;
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// monitor: predict on accepted requests, check accepted results, watchdog
	always @(posedge clk) begin : monitor
		rsp_t w;
		rsp_t due;
		int   stall;
		if (!arst_n) begin
			foreach (counters[i]) counters[i] = '0;
			age_limit = THRESH_RESET;
			stall     = 0;
			n_done    <= 0;
		end else begin
			stall++;
			if (req_bus.valid && req_bus.ready) begin
				stall = 0;
				w = score_after(req_bus.func, req_bus.piece, req_bus.square, req_bus.depth);
				if (pin_flag) w = pin_word;
				scores_due.push_back(w);
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				stall = 0;
				n_done <= n_done + 1;
				if (scores_due.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					due = scores_due.pop_front();
					if (rsp_bus.score !== due.score)
						report_mismatch($sformatf("score %0d, want %0d", rsp_bus.score, due.score));
					if (rsp_bus.aged !== due.aged)
						report_mismatch($sformatf("aged %b, want %b", rsp_bus.aged, due.aged));
					if (rsp_bus.rejected !== due.rejected)
						report_mismatch($sformatf("rejected %b, want %b",
							rsp_bus.rejected, due.rejected));
				end
			end
			// register port: write updates the model, read must match it
			if (psel && penable && pready) begin
				stall = 0;
				if (pwrite && paddr == THRESH_ADDR) begin
					age_limit = pwdata[SCORE_W-1:0];
				end else if (!pwrite && prdata !== PDATA_W'(age_limit)) begin
					report_mismatch($sformatf("threshold reads %0d, want %0d", prdata, age_limit));
				end
			end
			if (stall >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("history_counter_table_with_aging_core_test: FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [FUNC_W-1:0] f, input logic signed [PIECE_W-1:0] pc,
			input logic [SQUARE_W-1:0] sq, input logic [DEPTH_W-1:0] d,
			input logic pin, input rsp_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid  <= 1'b1;
		req_bus.func   <= f;
		req_bus.piece  <= pc;
		req_bus.square <= sq;
		req_bus.depth  <= d;
		pin_flag       <= pin;
		pin_word       <= want;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		n_sent++;
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic drain();
		while (n_done != n_sent) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// threshold write and read back, only once the block has gone idle
	task automatic write_thresh(input logic [SCORE_W-1:0] v);
		drain();
		while (!req_bus.ready) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= THRESH_ADDR;
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// random words, mostly hammering one hot entry so it reaches aging and saturation
	task automatic run_traffic(input int words);
		logic [FUNC_W-1:0]          f;
		logic signed [PIECE_W-1:0]  pc;
		logic [SQUARE_W-1:0]        sq;
		logic [DEPTH_W-1:0]         d;
		logic signed [PIECE_W-1:0]  hot_piece;
		logic [SQUARE_W-1:0]        hot_square;
		int                         useful;
		int                         pick;
		useful     = 0;
		hot_piece  = PIECE_W'(int'($urandom_range(PIECE_KINDS - 1)) - 6);
		hot_square = SQUARE_W'($urandom_range(SQUARES - 1));
		while (useful < words) begin
			if ($urandom_range(99) == 0) begin
				hot_piece  = PIECE_W'(int'($urandom_range(PIECE_KINDS - 1)) - 6);
				hot_square = SQUARE_W'($urandom_range(SQUARES - 1));
			end
			pick = $urandom_range(199);
			if (pick == 0) f = FUNC_CLEAR;
			else if (pick < 5) f = FUNC_UNKNOWN;
			else if (pick < 70) f = FUNC_LOOKUP;
			else f = FUNC_UPDATE;
			if ($urandom_range(99) < 75) begin
				pc = hot_piece;
				sq = hot_square;
			end else begin
				pc = PIECE_W'($urandom_range(15));
				sq = SQUARE_W'($urandom_range(63));
			end
			d = ($urandom_range(99) < 60) ? DEPTH_W'($urandom_range(63, 32))
				: DEPTH_W'($urandom_range(63));
			if ($urandom_range(299) == 0) drain();
			send_word(f, pc, sq, d, 1'b0, '0);
			if (f == FUNC_CLEAR || (f != FUNC_UNKNOWN && int'(pc) >= -6 && int'(pc) <= 6))
				useful++;
		end
	endtask

	// stimulus
	initial begin : driver
		logic [SCORE_W-1:0] limits [6];
		limits = '{THRESH_RESET, '0, THRESH_TOP, THRESH_HIGH, THRESH_LOW,
			SCORE_W'($urandom_range(131071))};
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		req_bus.valid  <= 1'b0;
		req_bus.func   <= '0;
		req_bus.piece  <= '0;
		req_bus.square <= '0;
		req_bus.depth  <= '0;
		pin_flag       <= 1'b0;
		pin_word       <= '0;
		src_idle_pct   = 6;
		snk_idle_pct   <= 50;
		n_sent         = 0;
		errors         = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_THRESH)
				write_thresh(SCORE_W'(plan[i].thresh));
			else
				send_word(plan[i].func, PIECE_W'(plan[i].piece), SQUARE_W'(plan[i].square),
					DEPTH_W'(plan[i].depth), plan[i].pinned, plan[i].want);
		end

		// random phases: sender idles lightly, then receiver lightly, then neither
		for (int p = 0; p < 6; p++) begin
			write_thresh(limits[p]);
			src_idle_pct = (p < 2) ? 6 : (p < 4) ? 50 : 0;
			snk_idle_pct <= (p < 2) ? 50 : (p < 4) ? 6 : 0;
			run_traffic(PHASE_WORDS);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && scores_due.size() == 0) begin
			$display("history_counter_table_with_aging_core_test: PASS");
		end else begin
			if (scores_due.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", scores_due.size()));
			$display("history_counter_table_with_aging_core_test: FAIL");
		end
		$finish;
	end

endmodule
